// File: design/aesbe_pkg.sv
// Shared types, constants and round functions for the AES block engine.
package aesbe_pkg;

    // Sixteen state bytes; byte 0 sits in the most significant position.
    typedef logic [0:15][7:0] blk_t;
    typedef logic [255:0][7:0] sbox_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY_SIZE  = 3'd0;
    localparam logic [2:0] REG_OPERATION = 3'd1;
    localparam logic [2:0] REG_KEY_WORD0 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD1 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD2 = 3'd4;
    localparam logic [2:0] REG_KEY_WORD3 = 3'd5;
    localparam logic [2:0] REG_IV_HIGH   = 3'd6;
    localparam logic [2:0] REG_IV_LOW    = 3'd7;

    // Key length codes, in 32-bit words.
    localparam logic [1:0] NK4 = 2'd0;
    localparam logic [1:0] NK6 = 2'd1;
    localparam logic [1:0] NK8 = 2'd2;

    localparam int NUM_STAGES = 16;
    localparam int NUM_WORDS  = 60;
    localparam logic [5:0] LAST_WORD = 6'd59;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x;
            x = xtime(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'h01;
        x = a;
        for (int i = 0; i < 7; i++) begin
            x = gf_mul(x, x);
            r = gf_mul(r, x);
        end
        return r;
    endfunction

    function automatic sbox_t gen_sbox();
        sbox_t t;
        logic [7:0] b;
        for (int i = 0; i < 256; i++) begin
            b = gf_inv(8'(i));
            t[i] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                 ^ {b[3:0], b[7:4]} ^ 8'h63;
        end
        return t;
    endfunction

    function automatic sbox_t gen_inv_sbox();
        sbox_t f;
        sbox_t t;
        f = gen_sbox();
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[f[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam sbox_t SBOX     = gen_sbox();
    localparam sbox_t INV_SBOX = gen_inv_sbox();

    function automatic logic [7:0] mul9(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    // SubBytes, ShiftRows, then MixColumns unless this is the final round.
    function automatic blk_t enc_round(input blk_t s, input logic last);
        blk_t t;
        blk_t m;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = SBOX[s[4*((c+r)&3)+r]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
            m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
        end
        return last ? t : m;
    endfunction

    // InvShiftRows, InvSubBytes, AddRoundKey, then InvMixColumns unless last.
    function automatic blk_t dec_round(input blk_t s, input blk_t key, input logic last);
        blk_t t;
        blk_t m;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*((c+r)&3)+r] = INV_SBOX[s[4*c+r]];
            end
        end
        t = t ^ key;
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = mul14(t[4*c]) ^ mul11(t[4*c+1]) ^ mul13(t[4*c+2]) ^ mul9(t[4*c+3]);
            m[4*c+1] = mul9(t[4*c]) ^ mul14(t[4*c+1]) ^ mul11(t[4*c+2]) ^ mul13(t[4*c+3]);
            m[4*c+2] = mul13(t[4*c]) ^ mul9(t[4*c+1]) ^ mul14(t[4*c+2]) ^ mul11(t[4*c+3]);
            m[4*c+3] = mul11(t[4*c]) ^ mul13(t[4*c+1]) ^ mul9(t[4*c+2]) ^ mul14(t[4*c+3]);
        end
        return last ? t : m;
    endfunction

endpackage

// File: design/aes_block_engine_ecb_cbc.sv
// AES block engine (ECB/CBC, 128/192/256-bit keys) with a round-per-stage pipeline.
//
// Blocks enter on the s_ channel and leave on the m_ channel, one result per
// input block, in order. Configuration registers are written through cfg_we,
// cfg_index and cfg_wdata while the engine is idle. Every configuration write
// restarts the key schedule, which builds one 32-bit round key word per cycle;
// s_tready stays low while it runs. After reset the schedule for the all-zero
// key runs the same way, so the first block is taken only once it has finished.
// The data path has 16 register stages: the initial key addition, 14 round
// stages (shorter keys pass through the leading ones) and the CBC output stage.
// Blocks pass through the stages in order; one block can be accepted every
// cycle while the key schedule is idle. Each stage holds its item when the
// stage after it is full, so a stall on m_tready fills empty stages first and
// then back-pressures s_tready; nothing is lost or repeated.
module aes_block_engine_ecb_cbc (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_high [63:0], result_low [127:64]
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);
    import aesbe_pkg::*;

    logic [1:0]  key_size_reg;
    logic [1:0]  operation_reg;
    logic [63:0] key_word0_reg, key_word1_reg, key_word2_reg, key_word3_reg;
    logic [63:0] iv_high_reg, iv_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg  <= '0;
            operation_reg <= '0;
            key_word0_reg <= '0;
            key_word1_reg <= '0;
            key_word2_reg <= '0;
            key_word3_reg <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_SIZE:  key_size_reg  <= cfg_wdata[1:0];
                REG_OPERATION: operation_reg <= cfg_wdata[1:0];
                REG_KEY_WORD0: key_word0_reg <= cfg_wdata;
                REG_KEY_WORD1: key_word1_reg <= cfg_wdata;
                REG_KEY_WORD2: key_word2_reg <= cfg_wdata;
                REG_KEY_WORD3: key_word3_reg <= cfg_wdata;
                REG_IV_HIGH:   iv_high_reg   <= cfg_wdata;
                REG_IV_LOW:    iv_low_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    logic   decrypt, cbc;
    logic [1:0] nk;
    blk_t   iv;

    assign decrypt = operation_reg[0];
    assign cbc     = operation_reg[1];
    assign iv      = {iv_high_reg, iv_low_reg};

    always_comb begin
        priority if (key_size_reg[1]) nk = NK8;
        else if (key_size_reg[0])     nk = NK6;
        else                          nk = NK4;
    end

    // Key schedule: words shift in at the top of a 60-word line, so after a
    // full run word j of the expanded key sits at position j.
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  mod_reg, mod_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] line_reg [NUM_WORDS];
    logic [31:0] new_word, prev_word, back_word, key_word;
    logic [2:0]  nk_last;
    logic        from_key;

    always_comb begin
        unique case (cnt_reg[2:0])
            3'd0: key_word = key_word0_reg[63:32];
            3'd1: key_word = key_word0_reg[31:0];
            3'd2: key_word = key_word1_reg[63:32];
            3'd3: key_word = key_word1_reg[31:0];
            3'd4: key_word = key_word2_reg[63:32];
            3'd5: key_word = key_word2_reg[31:0];
            3'd6: key_word = key_word3_reg[63:32];
            3'd7: key_word = key_word3_reg[31:0];
            default: key_word = '0;
        endcase
        unique case (nk)
            NK8:     begin back_word = line_reg[52]; nk_last = 3'd7; end
            NK6:     begin back_word = line_reg[54]; nk_last = 3'd5; end
            default: begin back_word = line_reg[56]; nk_last = 3'd3; end
        endcase
        from_key  = (cnt_reg <= {3'd0, nk_last});
        prev_word = line_reg[NUM_WORDS-1];
        new_word  = prev_word;
        if (mod_reg == 3'd0) begin
            new_word = {SBOX[prev_word[23:16]] ^ rcon_reg, SBOX[prev_word[15:8]],
                        SBOX[prev_word[7:0]], SBOX[prev_word[31:24]]};
        end else if (nk == NK8 && mod_reg == 3'd4) begin
            new_word = {SBOX[prev_word[31:24]], SBOX[prev_word[23:16]],
                        SBOX[prev_word[15:8]], SBOX[prev_word[7:0]]};
        end
        new_word = from_key ? key_word : (new_word ^ back_word);

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        mod_next  = mod_reg;
        rcon_next = rcon_reg;
        if (cfg_we) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mod_next  = '0;
            rcon_next = 8'h01;
        end else if (busy_reg) begin
            cnt_next  = cnt_reg + 6'd1;
            mod_next  = (mod_reg == nk_last) ? 3'd0 : mod_reg + 3'd1;
            if (!from_key && mod_reg == 3'd0) rcon_next = xtime(rcon_reg);
            if (cnt_reg == LAST_WORD) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            mod_reg  <= mod_next;
            rcon_reg <= rcon_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !cfg_we) begin
            for (int j = 0; j < NUM_WORDS - 1; j++) line_reg[j] <= line_reg[j+1];
            line_reg[NUM_WORDS-1] <= new_word;
        end
    end

    blk_t rk [15];
    for (genvar r = 0; r < 15; r++) begin : g_rk
        assign rk[r] = {line_reg[4*r], line_reg[4*r+1], line_reg[4*r+2], line_reg[4*r+3]};
    end

    // Data pipeline.
    blk_t st_reg [NUM_STAGES];
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] rdy;
    blk_t st_next [NUM_STAGES];

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
        if (k == NUM_STAGES - 1) begin : g_last
            assign rdy[k] = !v_reg[k] || m_tready;
        end else begin : g_mid
            assign rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0] && !busy_reg;

    blk_t in_blk, rk_first;
    assign in_blk = {s_tdata[63:0], s_tdata[127:64]};

    always_comb begin
        unique case (nk)
            NK8:     rk_first = decrypt ? rk[14] : rk[0];
            NK6:     rk_first = decrypt ? rk[12] : rk[0];
            default: rk_first = decrypt ? rk[10] : rk[0];
        endcase
        st_next[0] = in_blk ^ ((cbc && !decrypt) ? iv : '0) ^ rk_first;
        st_next[NUM_STAGES-1] = st_reg[NUM_STAGES-2] ^ ((cbc && decrypt) ? iv : '0);
    end

    // Round stage k runs round k-(14-Nr) when encrypting and inverse round
    // 14-k when decrypting; stages before the first active one pass through.
    for (genvar k = 1; k < NUM_STAGES - 1; k++) begin : g_round
        localparam int E10 = (k > 4) ? k - 4 : 0;
        localparam int E12 = (k > 2) ? k - 2 : 0;
        logic active;
        blk_t key;
        always_comb begin
            unique case (nk)
                NK8: begin active = 1'b1;    key = decrypt ? rk[14-k] : rk[k];   end
                NK6: begin active = (k > 2); key = decrypt ? rk[14-k] : rk[E12]; end
                default: begin
                    active = (k > 4);
                    key    = decrypt ? rk[14-k] : rk[E10];
                end
            endcase
            if (!active) begin
                st_next[k] = st_reg[k-1];
            end else if (decrypt) begin
                st_next[k] = dec_round(st_reg[k-1], key, k == NUM_STAGES - 2);
            end else begin
                st_next[k] = enc_round(st_reg[k-1], k == NUM_STAGES - 2) ^ key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    if (k == 0) v_reg[k] <= s_tvalid && s_tready;
                    else        v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) st_reg[0] <= st_next[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k] && v_reg[k-1]) st_reg[k] <= st_next[k];
        end
    end

    assign m_tvalid = v_reg[NUM_STAGES-1];
    assign m_tdata  = {st_reg[NUM_STAGES-1][8:15], st_reg[NUM_STAGES-1][0:7]};

    a_busy_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> busy_reg)
        else $error("key schedule did not restart after a register write");

    a_sched_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == LAST_WORD && !cfg_we |=> !busy_reg)
        else $error("key schedule ran past its last word");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("block taken while key schedule runs");

    a_hold_first: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] && !rdy[1] |=> v_reg[0] && $stable(st_reg[0]))
        else $error("first stage lost its block while stalled");

endmodule

// File: test/tb.sv
// Self-checking testbench for the pipelined AES ECB/CBC block engine.
module tb;
    import aesbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 16;
    localparam int IDLE_LIMIT = 5000;

    typedef logic [7:0] byte_t;
    typedef byte_t state_t [16];

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // block_high [63:0], block_low [127:64]
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // result_high [63:0], result_low [127:64]
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wdata;

    aes_block_engine_ecb_cbc dut (.*);

    // Local copy of the engine's configuration.
    logic [1:0]  key_len;
    logic [1:0]  mode;
    logic [63:0] key_w [4];
    logic [63:0] iv_hi;
    logic [63:0] iv_lo;

    logic [127:0] expected_blocks [$];
    int errors;
    int blocks_sent;
    int blocks_checked;
    int idle_cycles;
    bit sender_idles;
    bit sink_idles;
    bit sink_hold;
    int hold_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic byte_t mul_gf(byte_t a, byte_t b);
        byte_t acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic byte_t inv_gf(byte_t x);
        byte_t r;
        r = 8'h01;
        for (int i = 0; i < 7; i++) begin
            x = mul_gf(x, x);
            r = mul_gf(r, x);
        end
        return r;
    endfunction

    function automatic byte_t rol8(byte_t b, int n);
        return (b << n) | (b >> (8 - n));
    endfunction

    function automatic byte_t fwd_sub(byte_t x);
        byte_t b;
        b = inv_gf(x);
        return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    endfunction

    function automatic byte_t rev_sub(byte_t x);
        return inv_gf(rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05);
    endfunction

    // Computes the block the engine should return for one input block.
    function automatic logic [127:0] aes_result(logic [63:0] hi, logic [63:0] lo);
        byte_t  rk [240];
        byte_t  tw [4];
        byte_t  f;
        byte_t  rcon;
        state_t s;
        state_t t;
        byte_t  a0, a1, a2, a3;
        int     nk, nr;
        bit     dec, cbc;
        logic [127:0] blk;
        dec  = mode[0];
        cbc  = mode[1];
        nk   = key_len[1] ? 8 : (key_len[0] ? 6 : 4);
        nr   = nk + 6;
        rcon = 8'h01;
        for (int i = 0; i < 32; i++) rk[i] = key_w[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            for (int j = 0; j < 4; j++) tw[j] = rk[4 * (i - 1) + j];
            if (i % nk == 0) begin
                f = tw[0];
                tw[0] = fwd_sub(tw[1]) ^ rcon;
                tw[1] = fwd_sub(tw[2]);
                tw[2] = fwd_sub(tw[3]);
                tw[3] = fwd_sub(f);
                rcon = mul_gf(rcon, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                for (int j = 0; j < 4; j++) tw[j] = fwd_sub(tw[j]);
            end
            for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - nk) + j] ^ tw[j];
        end
        blk = {hi, lo};
        if (cbc && !dec) blk ^= {iv_hi, iv_lo};
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
        if (!dec) begin
            for (int i = 0; i < 16; i++) s[i] ^= rk[i];
            for (int rnd = 1; rnd <= nr; rnd++) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4 * c + r] = fwd_sub(s[4 * ((c + r) & 3) + r]);
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    if (rnd != nr) begin
                        s[4 * c]     = mul_gf(a0, 2) ^ mul_gf(a1, 3) ^ a2 ^ a3;
                        s[4 * c + 1] = a0 ^ mul_gf(a1, 2) ^ mul_gf(a2, 3) ^ a3;
                        s[4 * c + 2] = a0 ^ a1 ^ mul_gf(a2, 2) ^ mul_gf(a3, 3);
                        s[4 * c + 3] = mul_gf(a0, 3) ^ a1 ^ a2 ^ mul_gf(a3, 2);
                    end else begin
                        s[4 * c] = a0; s[4 * c + 1] = a1; s[4 * c + 2] = a2; s[4 * c + 3] = a3;
                    end
                end
                for (int i = 0; i < 16; i++) s[i] ^= rk[16 * rnd + i];
            end
        end else begin
            for (int i = 0; i < 16; i++) s[i] ^= rk[16 * nr + i];
            for (int rnd = nr - 1; rnd >= 0; rnd--) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        t[4 * ((c + r) & 3) + r] = rev_sub(s[4 * c + r]);
                for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16 * rnd + i];
                if (rnd != 0) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                        s[4 * c] = mul_gf(a0, 14) ^ mul_gf(a1, 11) ^ mul_gf(a2, 13)
                                 ^ mul_gf(a3, 9);
                        s[4 * c + 1] = mul_gf(a0, 9) ^ mul_gf(a1, 14) ^ mul_gf(a2, 11)
                                     ^ mul_gf(a3, 13);
                        s[4 * c + 2] = mul_gf(a0, 13) ^ mul_gf(a1, 9) ^ mul_gf(a2, 14)
                                     ^ mul_gf(a3, 11);
                        s[4 * c + 3] = mul_gf(a0, 11) ^ mul_gf(a1, 13) ^ mul_gf(a2, 9)
                                     ^ mul_gf(a3, 14);
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = s[i];
        if (cbc && dec) blk ^= {iv_hi, iv_lo};
        // Result word order on the port: result_high low, result_low high.
        return {blk[63:0], blk[127:64]};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
        errors++;
    endtask

    // Writes one register while the engine is idle and mirrors it locally.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_KEY_SIZE:  key_len = value[1:0];
            REG_OPERATION: mode = value[1:0];
            REG_KEY_WORD0: key_w[0] = value;
            REG_KEY_WORD1: key_w[1] = value;
            REG_KEY_WORD2: key_w[2] = value;
            REG_KEY_WORD3: key_w[3] = value;
            REG_IV_HIGH:   iv_hi = value;
            REG_IV_LOW:    iv_lo = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // The valid stays high after a transfer so that back-to-back blocks need
    // no gap; it drops on an idle cycle, in drain() or in write_reg().
    task automatic send_block(logic [63:0] hi, logic [63:0] lo);
        while (sender_idles && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lo, hi};
        expected_blocks.push_back(aes_result(hi, lo));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        blocks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic configure(logic [1:0] ks, logic [1:0] op);
        write_reg(REG_KEY_SIZE, {62'($urandom), ks});
        write_reg(REG_OPERATION, {62'($urandom), op});
        for (int i = 0; i < 4; i++)
            write_reg(3'(REG_KEY_WORD0 + i), {$urandom, $urandom});
        write_reg(REG_IV_HIGH, {$urandom, $urandom});
        write_reg(REG_IV_LOW, {$urandom, $urandom});
    endtask

    task automatic test_reset_config();
        // All-zero key in ECB encrypt, straight after reset: an all-zero and an all-one block.
        send_block('0, '0);
        send_block('1, '1);
        drain();
    endtask

    task automatic test_known_vectors();
        // FIPS-197 appendix C vectors, all three key lengths, both directions.
        logic [63:0] pt_hi, pt_lo;
        pt_hi = 64'h0011223344556677;
        pt_lo = 64'h8899aabbccddeeff;
        write_reg(REG_KEY_WORD0, 64'h0001020304050607);
        write_reg(REG_KEY_WORD1, 64'h08090a0b0c0d0e0f);
        write_reg(REG_KEY_WORD2, 64'h1011121314151617);
        write_reg(REG_KEY_WORD3, 64'h18191a1b1c1d1e1f);
        for (int op = 0; op < 4; op++) begin
            write_reg(REG_OPERATION, 64'(op));
            for (int ks = 0; ks < 4; ks++) begin
                // A size of three selects the 256-bit key, like two.
                write_reg(REG_KEY_SIZE, 64'(ks));
                send_block(pt_hi, pt_lo);
                drain();
            end
            if (op == 1) begin
                write_reg(REG_IV_HIGH, '1);
                write_reg(REG_IV_LOW, 64'h8000000000000001);
            end
        end
    endtask

    task automatic test_extremes();
        write_reg(REG_OPERATION, 64'd2);
        send_block('0, '1);
        send_block('1, '0);
        send_block(64'h8000000000000001, 64'h0123456789abcdef);
        drain();
        write_reg(REG_KEY_SIZE, 64'd0);
        write_reg(REG_KEY_WORD2, '1);   // unused by a 128-bit key
        write_reg(REG_KEY_WORD0, '1);
        write_reg(REG_KEY_WORD1, '1);
        write_reg(REG_OPERATION, 64'd3);
        send_block('1, '1);
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 16; ph++) begin
            configure(2'($urandom_range(3)), 2'(ph));
            sender_idles = (ph != 5);
            sink_idles   = (ph != 5);
            for (int n = 0; n < 64; n++) send_block({$urandom, $urandom}, {$urandom, $urandom});
            // Full pause until every result is back before the next setup.
            drain();
        end
        sender_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    task automatic test_backpressure();
        configure(2'd2, 2'd3);
        sink_hold   = 1'b1;
        hold_cycles = 0;
        fork
            begin
                for (int n = 0; n < 40; n++)
                    send_block({$urandom, $urandom}, {$urandom, $urandom});
            end
            begin
                while (hold_cycles < 200) @(posedge aclk);
                sink_hold <= 1'b0;
            end
        join
        drain();
    endtask

    // Result sink: random stalls plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (sink_hold) hold_cycles <= hold_cycles + 1;
            m_tready <= !sink_hold && !(sink_idles && $urandom_range(99) < 27);
        end
    end

    always @(posedge aclk) begin
        logic [127:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_blocks.size() == 0) begin
                $display("unexpected result %h at %0t", m_tdata, $realtime);
                errors++;
            end else begin
                want = expected_blocks.pop_front();
                if (m_tdata[63:0] !== want[63:0])
                    report_mismatch("result_high", m_tdata[63:0], want[63:0]);
                if (m_tdata[127:64] !== want[127:64])
                    report_mismatch("result_low", m_tdata[127:64], want[127:64]);
                blocks_checked++;
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel and no register write.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        errors = 0; blocks_sent = 0; blocks_checked = 0; idle_cycles = 0;
        sender_idles = 1'b1; sink_idles = 1'b1; sink_hold = 1'b0; hold_cycles = 0;
        key_len = '0; mode = '0; iv_hi = '0; iv_lo = '0;
        for (int i = 0; i < 4; i++) key_w[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_known_vectors();
        test_extremes();
        test_random_phases();
        test_backpressure();
        $display("Covered %0d blocks, %0d results checked: all key sizes, ECB/CBC, both directions.",
                 blocks_sent, blocks_checked);
        $display("Random stalls on both sides, a long sink hold-off and a drained pause.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: sim.f
design/aesbe_pkg.sv
design/aes_block_engine_ecb_cbc.sv
test/tb.sv
